### design/wsfd_pkg.sv
// Shared types and constants for the WebSocket frame decoder.
// No dependencies; imported by websocket_frame_decoder.
package wsfd_pkg;

    // Frame opcodes
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'hA;

    // Header bit masks and length codes
    localparam logic [7:0] HDR_FIN_MASK  = 8'h80;
    localparam logic [7:0] HDR_RSV_MASK  = 8'h70;
    localparam logic [7:0] HDR_OP_MASK   = 8'h0f;
    localparam logic [7:0] HDR_LEN_MASK  = 8'h7f;
    localparam logic [6:0] LEN_EXT16     = 7'h7e;
    localparam logic [6:0] LEN_EXT64     = 7'h7f;

    // Frame status codes
    localparam logic [1:0] ST_TEXT   = 2'd0;
    localparam logic [1:0] ST_IGNORE = 2'd1;
    localparam logic [1:0] ST_CLOSE  = 2'd2;
    localparam logic [1:0] ST_ERROR  = 2'd3;

    // Result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    localparam int POS_W  = 17;
    localparam logic [POS_W-1:0] POS_MAX = '1;

    // Result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);
    // Room for two results is needed before a byte is taken
    localparam logic [FIFO_CW-1:0] FIFO_ACCEPT_MAX = FIFO_CW'(FIFO_DEPTH - 2);

    typedef struct packed {
        logic       kind;
        logic [7:0] payload_byte;
        logic [1:0] status;
        logic       last;
    } t_result;

endpackage

### design/websocket_frame_decoder.sv
// WebSocket frame decoder (client to server), one frame byte per transfer.
// Depends on wsfd_pkg for opcodes, status codes and the result type.
//
// Input channel: i_valid / o_stall carry i_data_byte and i_frame_end; the
// byte with i_frame_end high is the last byte of a frame.
// Output channel: o_valid / i_stall carry o_kind, o_payload_byte, o_status
// and o_last. A text frame gives one unmasked payload item per payload
// byte while no error has been found; the last byte of every frame gives
// a status item (o_last high), after its payload item if it has one.
// Each byte is decoded in the cycle it is taken: header checks, length and
// key capture and the unmasking XOR are one step of logic on the frame
// state, and its results are written into a four-entry result queue.
// Results are registered in the queue and read out in order. One byte is
// taken per cycle; the input stalls only while the queue has room for
// fewer than two results.
// When the receiver holds i_stall, the queue fills and o_stall rises once
// three or more results wait; nothing is dropped.
// Synchronous reset clears the frame state and empties the queue.
module websocket_frame_decoder
    import wsfd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_frame_end,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_kind,
    output logic [7:0] o_payload_byte,
    output logic [1:0] o_status,
    output logic       o_last
);

    // Frame state
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [3:0]         r_op, n_op;
    logic [15:0]        r_len, n_len;
    logic               r_ext, n_ext;
    logic [31:0]        r_key, n_key;
    logic               r_err, n_err;

    // Result queue
    t_result            r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [FIFO_CW-1:0] r_count;

    logic               accept, pop;
    logic               is_text;
    logic [2:0]         hdr, end_hdr;
    logic [POS_W-1:0]   pay_lo, pay_hi, end_need;
    logic [POS_W:0]     pos_plus1;
    logic [1:0]         key_idx;
    logic [7:0]         key_byte;
    logic [3:0]         op_in;
    logic [6:0]         len7;
    logic [1:0]         st;
    t_result            res0, res1;
    logic [1:0]         n_res;

    assign o_stall = r_count > FIFO_ACCEPT_MAX;
    assign accept  = i_valid && !o_stall;
    assign o_valid = r_count != '0;
    assign pop     = o_valid && !i_stall;

    assign o_kind         = r_fifo[r_rd_ptr].kind;
    assign o_payload_byte = r_fifo[r_rd_ptr].payload_byte;
    assign o_status       = r_fifo[r_rd_ptr].status;
    assign o_last         = r_fifo[r_rd_ptr].last;

    assign is_text   = r_op == OP_TEXT;
    assign hdr       = r_ext ? 3'd4 : 3'd2;
    assign pay_lo    = POS_W'(hdr) + POS_W'(4);
    assign pay_hi    = pay_lo + POS_W'(r_len);
    assign key_idx   = r_pos[1:0] - hdr[1:0];
    assign op_in     = i_data_byte[3:0] & HDR_OP_MASK[3:0];
    assign len7      = i_data_byte[6:0] & HDR_LEN_MASK[6:0];
    assign pos_plus1 = {1'b0, r_pos} + (POS_W+1)'(1);

    always_comb begin
        case (key_idx)
            2'd0:    key_byte = r_key[7:0];
            2'd1:    key_byte = r_key[15:8];
            2'd2:    key_byte = r_key[23:16];
            default: key_byte = r_key[31:24];
        endcase
    end

    // Decode one byte against the frame state
    always_comb begin
        n_pos = r_pos;
        n_op  = r_op;
        n_len = r_len;
        n_ext = r_ext;
        n_key = r_key;
        n_err = r_err;
        n_res = 2'd0;
        res0  = '0;
        res1  = '0;
        st    = ST_TEXT;

        if (r_pos == '0) begin
            n_op = op_in;
            if ((i_data_byte & HDR_RSV_MASK) != 8'h00 ||
                (i_data_byte & HDR_FIN_MASK) != HDR_FIN_MASK) begin
                n_err = 1'b1;
            end
            if (op_in != OP_TEXT && op_in != OP_BINARY && op_in != OP_CLOSE &&
                op_in != OP_PING && op_in != OP_PONG) begin
                n_err = 1'b1;
            end
        end else if (r_pos == POS_W'(1)) begin
            if ((i_data_byte & HDR_FIN_MASK) != HDR_FIN_MASK) begin
                n_err = 1'b1;
            end
            if (is_text) begin
                if (len7 == LEN_EXT16) begin
                    n_ext = 1'b1;
                    n_len = '0;
                end else if (len7 == LEN_EXT64) begin
                    n_err = 1'b1;
                    n_len = '0;
                end else begin
                    n_len = 16'(len7);
                end
            end
        end else if (is_text) begin
            if (r_ext && r_pos == POS_W'(2)) begin
                n_len = {i_data_byte, 8'h00};
            end else if (r_ext && r_pos == POS_W'(3)) begin
                n_len = {r_len[15:8], i_data_byte};
            end else if (r_pos >= POS_W'(hdr) && r_pos < pay_lo) begin
                case (key_idx)
                    2'd0:    n_key[7:0]   = i_data_byte;
                    2'd1:    n_key[15:8]  = i_data_byte;
                    2'd2:    n_key[23:16] = i_data_byte;
                    default: n_key[31:24] = i_data_byte;
                endcase
            end else if (r_pos >= pay_lo && r_pos < pay_hi && !r_err) begin
                res0.kind         = KIND_PAYLOAD;
                res0.payload_byte = i_data_byte ^ key_byte;
                n_res             = 2'd1;
            end
        end

        if (r_pos != POS_MAX) begin
            n_pos = r_pos + POS_W'(1);
        end

        // Length the frame needs, taken before the state is cleared
        end_hdr  = n_ext ? 3'd4 : 3'd2;
        end_need = POS_W'(end_hdr) + POS_W'(4) + POS_W'(n_len);

        if (i_frame_end) begin
            if (r_pos == '0) begin
                n_err = 1'b1;
            end
            if (n_op == OP_TEXT) begin
                if (n_ext && r_pos < POS_W'(3)) begin
                    n_err = 1'b1;
                end else if (n_len != '0 && pos_plus1 < {1'b0, end_need}) begin
                    n_err = 1'b1;
                end
            end
            if (n_err) begin
                st = ST_ERROR;
            end else if (n_op == OP_TEXT) begin
                st = ST_TEXT;
            end else if (n_op == OP_CLOSE) begin
                st = ST_CLOSE;
            end else begin
                st = ST_IGNORE;
            end
            // Status goes after the payload item, if any
            if (n_res == 2'd1) begin
                res1.kind   = KIND_STATUS;
                res1.status = st;
                res1.last   = 1'b1;
                n_res       = 2'd2;
            end else begin
                res0.kind   = KIND_STATUS;
                res0.status = st;
                res0.last   = 1'b1;
                n_res       = 2'd1;
            end
            n_pos = '0;
            n_op  = '0;
            n_len = '0;
            n_ext = 1'b0;
            n_key = '0;
            n_err = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_op  <= '0;
            r_len <= '0;
            r_ext <= 1'b0;
            r_key <= '0;
            r_err <= 1'b0;
        end else if (accept) begin
            r_pos <= n_pos;
            r_op  <= n_op;
            r_len <= n_len;
            r_ext <= n_ext;
            r_key <= n_key;
            r_err <= n_err;
        end
    end

    // Queue payload: no reset needed
    always_ff @(posedge i_clk) begin
        if (accept && n_res != 2'd0) begin
            r_fifo[r_wr_ptr] <= res0;
        end
        if (accept && n_res == 2'd2) begin
            r_fifo[r_wr_ptr + FIFO_AW'(1)] <= res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (accept) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(n_res);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            r_count <= r_count + (accept ? FIFO_CW'(n_res) : '0)
                       - (pop ? FIFO_CW'(1) : '0);
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FIFO_CW'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_end_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_frame_end |=> o_valid)
        else $error("frame end produced no result");

    a_end_clears_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_frame_end |=> r_pos == '0 && !r_err)
        else $error("frame state not cleared after frame end");

    a_payload_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_PAYLOAD |-> !o_last && o_status == ST_TEXT)
        else $error("payload item carries status fields");

endmodule
